FILE: design/gmd_pkg.sv
// Shared types, codes and helpers for the grid maze DFS solver.
// No dependencies; used by controller, datapath, top level and checker.
package gmd_pkg;

  localparam int unsigned CoordW  = 6;
  localparam int unsigned CellW   = 2 * CoordW;
  localparam int unsigned SpW     = CellW + 1;
  localparam int unsigned Depth   = 1 << CellW;
  localparam int unsigned DimW    = 7;
  localparam logic [DimW-1:0] MaxDim = 7'd64;

  localparam logic [2:0] EV_START  = 3'd0;
  localparam logic [2:0] EV_MOVE   = 3'd1;
  localparam logic [2:0] EV_BACK   = 3'd2;
  localparam logic [2:0] EV_EXIT   = 3'd3;
  localparam logic [2:0] EV_NOEXIT = 3'd4;
  localparam logic [2:0] EV_IDLE   = 3'd5;

  localparam logic [1:0] PH_NOT_STARTED = 2'd0;
  localparam logic [1:0] PH_RUNNING     = 2'd1;
  localparam logic [1:0] PH_EXITING     = 2'd2;
  localparam logic [1:0] PH_DONE        = 2'd3;

  localparam logic [1:0] DIR_RIGHT = 2'd0;
  localparam logic [1:0] DIR_UP    = 2'd1;
  localparam logic [1:0] DIR_LEFT  = 2'd2;
  localparam logic [1:0] DIR_DOWN  = 2'd3;

  localparam logic [1:0] CODE_OPEN  = 2'd1;
  localparam logic [1:0] CODE_START = 2'd2;

  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  typedef struct packed {
    logic       load;
    logic       rd_start;
    logic       start_go;
    logic       latch_top;
    logic       adv_dir;
    logic       mark_top;
    logic       push_nb;
    logic       pop;
    logic       set_done;
    logic       set_exiting;
    logic       emit;
    logic [2:0] ev;
  } cmd_t;

  typedef struct packed {
    logic [1:0] phase;
    logic       start_valid;
    logic       start_is_exit;
    logic       sp_zero;
    logic       sp_one;
    logic       dir_ge4;
    logic       nb_in;
    logic       nb_ok;
    logic       nb_is_exit;
    logic       start_visited;
  } stat_t;

  function automatic logic [DimW-1:0] clamp_dim(input logic [DimW-1:0] v);
    logic [DimW-1:0] r;
    if (v == '0) r = 7'd1;
    else if (v > MaxDim) r = MaxDim;
    else r = v;
    return r;
  endfunction

endpackage

FILE: design/gmd_ctrl.sv
// Search sequencer for the maze solver: walks each step through memory reads.
// Depends on gmd_pkg; drives gmd_dp through cmd_t, watches stat_t.
module gmd_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  input  logic           mode_i,
  output logic           busy,
  input  gmd_pkg::stat_t stat_i,
  output gmd_pkg::cmd_t  cmd_o
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DISP   = 3'd1;
  localparam logic [2:0] S_CHKST  = 3'd2;
  localparam logic [2:0] S_LATCH  = 3'd3;
  localparam logic [2:0] S_EVAL   = 3'd4;
  localparam logic [2:0] S_CHK    = 3'd5;
  localparam logic [2:0] S_PUSH   = 3'd6;
  localparam logic [2:0] S_PREV   = 3'd7;

  logic [2:0] state_q, state_d;

  assign busy = (state_q != S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          if (mode_i) state_d = S_DISP;
          else cmd_o.load = 1'b1;
        end
      end
      S_DISP: begin
        unique case (stat_i.phase)
          gmd_pkg::PH_DONE: begin
            cmd_o.emit = 1'b1; cmd_o.ev = gmd_pkg::EV_IDLE; state_d = S_IDLE;
          end
          gmd_pkg::PH_EXITING: begin
            cmd_o.emit = 1'b1; cmd_o.ev = gmd_pkg::EV_EXIT;
            cmd_o.set_done = 1'b1; state_d = S_IDLE;
          end
          gmd_pkg::PH_NOT_STARTED: begin
            if (!stat_i.start_valid) begin
              cmd_o.emit = 1'b1; cmd_o.ev = gmd_pkg::EV_NOEXIT;
              cmd_o.set_done = 1'b1; state_d = S_IDLE;
            end else if (stat_i.start_is_exit) begin
              cmd_o.emit = 1'b1; cmd_o.ev = gmd_pkg::EV_EXIT;
              cmd_o.set_done = 1'b1; state_d = S_IDLE;
            end else begin
              cmd_o.rd_start = 1'b1; state_d = S_CHKST;
            end
          end
          default: begin
            if (stat_i.sp_zero) begin
              cmd_o.emit = 1'b1; cmd_o.ev = gmd_pkg::EV_NOEXIT;
              cmd_o.set_done = 1'b1; state_d = S_IDLE;
            end else begin
              state_d = S_LATCH;
            end
          end
        endcase
      end
      S_CHKST: begin
        cmd_o.emit = 1'b1;
        if (stat_i.start_visited) begin
          cmd_o.ev = gmd_pkg::EV_NOEXIT; cmd_o.set_done = 1'b1;
        end else begin
          cmd_o.ev = gmd_pkg::EV_START; cmd_o.start_go = 1'b1;
        end
        state_d = S_IDLE;
      end
      S_LATCH: begin
        cmd_o.latch_top = 1'b1; state_d = S_EVAL;
      end
      S_EVAL: begin
        if (stat_i.dir_ge4) begin
          cmd_o.pop = 1'b1;
          if (stat_i.sp_one) begin
            cmd_o.emit = 1'b1; cmd_o.ev = gmd_pkg::EV_NOEXIT;
            cmd_o.set_done = 1'b1; state_d = S_IDLE;
          end else begin
            state_d = S_PREV;
          end
        end else if (!stat_i.nb_in) begin
          cmd_o.adv_dir = 1'b1;
        end else begin
          state_d = S_CHK;
        end
      end
      S_CHK: begin
        if (stat_i.nb_ok) begin
          cmd_o.mark_top = 1'b1;
          if (stat_i.nb_is_exit) begin
            cmd_o.set_exiting = 1'b1; cmd_o.emit = 1'b1;
            cmd_o.ev = gmd_pkg::EV_MOVE; state_d = S_IDLE;
          end else begin
            state_d = S_PUSH;
          end
        end else begin
          cmd_o.adv_dir = 1'b1; state_d = S_EVAL;
        end
      end
      S_PUSH: begin
        cmd_o.push_nb = 1'b1; cmd_o.emit = 1'b1;
        cmd_o.ev = gmd_pkg::EV_MOVE; state_d = S_IDLE;
      end
      default: begin
        cmd_o.emit = 1'b1; cmd_o.ev = gmd_pkg::EV_BACK; state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_IDLE;
    else state_q <= state_d;
  end

endmodule

FILE: design/gmd_dp.sv
// Datapath of the maze solver: maps, stack, maze registers, result registers.
// Depends on gmd_pkg; commanded by gmd_ctrl.
module gmd_dp (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic                        cfg_idx_i,
  input  logic [gmd_pkg::DimW-1:0]    cfg_data_i,
  input  logic [1:0]                  cell_code_i,
  input  gmd_pkg::cmd_t               cmd_i,
  output gmd_pkg::stat_t              stat_o,
  output logic                        result_valid_o,
  output logic [2:0]                  event_kind_o,
  output logic [1:0]                  direction_o,
  output logic [gmd_pkg::CoordW-1:0]  cell_row_o,
  output logic [gmd_pkg::CoordW-1:0]  cell_col_o,
  output logic [gmd_pkg::CoordW-1:0]  back_row_o,
  output logic [gmd_pkg::CoordW-1:0]  back_col_o,
  output logic                        last_event_o
);

  localparam int unsigned CW = gmd_pkg::CoordW;
  localparam int unsigned XW = gmd_pkg::CellW;
  localparam int unsigned SW = gmd_pkg::SpW;
  localparam int unsigned DW = gmd_pkg::DimW;

  logic [DW-1:0] w_q, h_q;
  logic [CW-1:0] lrow_q, lcol_q;
  logic          sv_q, ev_q;
  logic [CW-1:0] srow_q, scol_q, erow_q, ecol_q;
  logic [1:0]    phase_q;
  logic [SW-1:0] sp_q;
  logic [XW-1:0] cur_q;
  logic [2:0]    dir_q;

  logic              open_mem [gmd_pkg::Depth];
  logic              vis_mem  [gmd_pkg::Depth];
  logic [XW+2:0]     stk_mem  [gmd_pkg::Depth];
  logic              open_rd_q, vis_rd_q;
  logic [XW+2:0]     stk_rd_q;

  // load position (a load after the search began restarts at cell zero)
  logic          restart;
  logic [CW-1:0] lr, lc;
  logic          at_zero, border, last_col, last_row;
  assign restart  = (phase_q != gmd_pkg::PH_NOT_STARTED);
  assign lr       = restart ? '0 : lrow_q;
  assign lc       = restart ? '0 : lcol_q;
  assign at_zero  = (lr == '0) && (lc == '0);
  assign last_col = ({1'b0, lc} + 7'd1) == w_q;
  assign last_row = ({1'b0, lr} + 7'd1) == h_q;
  assign border   = (lr == '0) || (lc == '0) || last_col || last_row;

  // neighbor of the current cell in the current direction
  logic [CW-1:0] cr, cc, nr, nc;
  logic          nb_in;
  logic [XW-1:0] nidx;
  assign cr = cur_q[XW-1:CW];
  assign cc = cur_q[CW-1:0];
  always_comb begin
    nr = cr;
    nc = cc;
    unique case (dir_q[1:0])
      gmd_pkg::DIR_RIGHT: begin nc = cc + 1'b1; nb_in = ({1'b0, cc} + 7'd1) < w_q; end
      gmd_pkg::DIR_UP:    begin nr = cr - 1'b1; nb_in = (cr != '0); end
      gmd_pkg::DIR_LEFT:  begin nc = cc - 1'b1; nb_in = (cc != '0); end
      default:            begin nr = cr + 1'b1; nb_in = ({1'b0, cr} + 7'd1) < h_q; end
    endcase
  end
  assign nidx = {nr, nc};

  logic [XW-1:0] sidx, map_raddr;
  logic [SW-1:0] stk_rsel;
  assign sidx      = {srow_q, scol_q};
  assign map_raddr = cmd_i.rd_start ? sidx : nidx;
  assign stk_rsel  = cmd_i.pop ? (sp_q - 13'd2) : (sp_q - 13'd1);

  assign stat_o.phase         = phase_q;
  assign stat_o.start_valid   = sv_q;
  assign stat_o.start_is_exit = ev_q && (srow_q == erow_q) && (scol_q == ecol_q);
  assign stat_o.sp_zero       = (sp_q == '0);
  assign stat_o.sp_one        = (sp_q == 13'd1);
  assign stat_o.dir_ge4       = dir_q[2];
  assign stat_o.nb_in         = nb_in;
  assign stat_o.nb_ok         = open_rd_q && !vis_rd_q;
  assign stat_o.nb_is_exit    = ev_q && (nr == erow_q) && (nc == ecol_q);
  assign stat_o.start_visited = vis_rd_q;

  // memories: one write and one registered read each
  logic              vis_we, vis_wd;
  logic [XW-1:0]     vis_wa;
  logic              stk_we;
  logic [XW-1:0]     stk_wa;
  logic [XW+2:0]     stk_wd;
  always_comb begin
    vis_we = 1'b0; vis_wa = nidx; vis_wd = 1'b1;
    stk_we = 1'b0; stk_wa = sp_q[XW-1:0]; stk_wd = {nidx, 3'd0};
    if (cmd_i.load) begin
      vis_we = 1'b1; vis_wa = {lr, lc}; vis_wd = 1'b0;
    end else if (cmd_i.start_go) begin
      vis_we = 1'b1; vis_wa = sidx;
      stk_we = 1'b1; stk_wa = '0; stk_wd = {sidx, 3'd0};
    end else if (cmd_i.mark_top) begin
      stk_we = 1'b1;
      stk_wa = stk_rsel[XW-1:0];
      stk_wd = {cur_q, dir_q + 3'd1};
    end else if (cmd_i.push_nb) begin
      vis_we = 1'b1; stk_we = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) open_mem[{lr, lc}] <= (cell_code_i == gmd_pkg::CODE_OPEN) ||
                                          (cell_code_i == gmd_pkg::CODE_START);
    if (vis_we) vis_mem[vis_wa] <= vis_wd;
    if (stk_we) stk_mem[stk_wa] <= stk_wd;
    open_rd_q <= open_mem[map_raddr];
    vis_rd_q  <= vis_mem[map_raddr];
    stk_rd_q  <= stk_mem[stk_rsel[XW-1:0]];
  end

  // maze and search registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_q <= gmd_pkg::MaxDim; h_q <= gmd_pkg::MaxDim;
      lrow_q <= '0; lcol_q <= '0;
      sv_q <= 1'b0; ev_q <= 1'b0;
      phase_q <= gmd_pkg::PH_NOT_STARTED;
      sp_q <= '0;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == gmd_pkg::REG_WIDTH) w_q <= gmd_pkg::clamp_dim(cfg_data_i);
      else h_q <= gmd_pkg::clamp_dim(cfg_data_i);
      lrow_q <= '0; lcol_q <= '0;
      sv_q <= 1'b0; ev_q <= 1'b0;
      phase_q <= gmd_pkg::PH_NOT_STARTED;
      sp_q <= '0;
    end else begin
      if (cmd_i.load) begin
        phase_q <= gmd_pkg::PH_NOT_STARTED;
        if (restart) sp_q <= '0;
        if (cell_code_i == gmd_pkg::CODE_START) sv_q <= 1'b1;
        else if (at_zero) sv_q <= 1'b0;
        if (cell_code_i == gmd_pkg::CODE_OPEN && border) ev_q <= 1'b1;
        else if (at_zero) ev_q <= 1'b0;
        if (last_col) begin
          lcol_q <= '0;
          lrow_q <= last_row ? '0 : lr + 1'b1;
        end else begin
          lcol_q <= lc + 1'b1;
          lrow_q <= lr;
        end
      end
      if (cmd_i.start_go) begin
        sp_q <= 13'd1; phase_q <= gmd_pkg::PH_RUNNING;
      end
      if (cmd_i.push_nb) sp_q <= sp_q + 1'b1;
      if (cmd_i.pop) sp_q <= sp_q - 1'b1;
      if (cmd_i.set_done) phase_q <= gmd_pkg::PH_DONE;
      if (cmd_i.set_exiting) phase_q <= gmd_pkg::PH_EXITING;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      if (cell_code_i == gmd_pkg::CODE_START) begin srow_q <= lr; scol_q <= lc; end
      if (cell_code_i == gmd_pkg::CODE_OPEN && border) begin erow_q <= lr; ecol_q <= lc; end
    end
    if (cmd_i.latch_top) begin
      cur_q <= stk_rd_q[XW+2:3];
      dir_q <= stk_rd_q[2:0];
    end else if (cmd_i.adv_dir) begin
      dir_q <= dir_q + 3'd1;
    end
  end

  // result registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) result_valid_o <= 1'b0;
    else result_valid_o <= cmd_i.emit;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      event_kind_o <= cmd_i.ev;
      direction_o  <= (cmd_i.ev == gmd_pkg::EV_MOVE) ? dir_q[1:0] : 2'd0;
      back_row_o   <= '0;
      back_col_o   <= '0;
      last_event_o <= (cmd_i.ev == gmd_pkg::EV_EXIT) || (cmd_i.ev == gmd_pkg::EV_NOEXIT);
      unique case (cmd_i.ev)
        gmd_pkg::EV_START: begin cell_row_o <= srow_q; cell_col_o <= scol_q; end
        gmd_pkg::EV_MOVE:  begin cell_row_o <= nr; cell_col_o <= nc; end
        gmd_pkg::EV_BACK: begin
          cell_row_o <= cr; cell_col_o <= cc;
          back_row_o <= stk_rd_q[XW+2:CW+3];
          back_col_o <= stk_rd_q[CW+2:3];
        end
        gmd_pkg::EV_EXIT:  begin cell_row_o <= erow_q; cell_col_o <= ecol_q; end
        default:           begin cell_row_o <= '0; cell_col_o <= '0; end
      endcase
    end
  end

endmodule

FILE: design/grid_maze_dfs_solver.sv
// Top level of the grid maze depth-first search solver.
// Depends on gmd_pkg, gmd_ctrl and gmd_dp.
//
// Usage:
//   Configuration: cfg_we_i writes cfg_data_i into register cfg_idx_i
//   (0 grid width, 1 grid height, clamped to 1..64); any write starts a new
//   maze. Write only while busy is low and no result is pending.
//   Commands: a transaction is accepted when start is high and busy is low.
//   mode_i = 0 loads the next cell (cell_code_i: wall, open, start) in
//   row-major order; it completes in the accepting cycle, busy stays low and
//   no result follows. mode_i = 1 asks for the next search event.
//   Results: each search command yields exactly one result transaction,
//   shown for one cycle with result_valid_o high. The receiver cannot stall.
//   A search command resolves idle, exit and no-exit events that follow from
//   the phase alone; the start event, moves and backtracks wait on registered
//   reads of the open, visited and stack memories (4096 entries each), one
//   read round trip per neighbor probe, and an out-of-grid direction is
//   skipped without a read. busy drops as the result shows, so the next
//   command can be accepted at the edge that takes the result.
//   Reset: maze empty, 64x64 grid, search not started; the maps need no
//   clearing pass since each load clears its own cell.
module grid_maze_dfs_solver (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic                        cfg_idx_i,
  input  logic [gmd_pkg::DimW-1:0]    cfg_data_i,
  input  logic                        start,
  output logic                        busy,
  input  logic                        mode_i,
  input  logic [1:0]                  cell_code_i,
  output logic                        result_valid_o,
  output logic [2:0]                  event_kind_o,
  output logic [1:0]                  direction_o,
  output logic [gmd_pkg::CoordW-1:0]  cell_row_o,
  output logic [gmd_pkg::CoordW-1:0]  cell_col_o,
  output logic [gmd_pkg::CoordW-1:0]  back_row_o,
  output logic [gmd_pkg::CoordW-1:0]  back_col_o,
  output logic                        last_event_o
);

  gmd_pkg::cmd_t  cmd;
  gmd_pkg::stat_t stat;

  // sequencer: one search command walks through its memory probes here
  gmd_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .mode_i (mode_i),
    .busy   (busy),
    .stat_i (stat),
    .cmd_o  (cmd)
  );

  // maps, stack and result registers
  gmd_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .cell_code_i    (cell_code_i),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .result_valid_o (result_valid_o),
    .event_kind_o   (event_kind_o),
    .direction_o    (direction_o),
    .cell_row_o     (cell_row_o),
    .cell_col_o     (cell_col_o),
    .back_row_o     (back_row_o),
    .back_col_o     (back_col_o),
    .last_event_o   (last_event_o)
  );

endmodule

FILE: design/gmd_chk.sv
// Port-level checker for the maze solver, bound to the top level.
// Depends on gmd_pkg and grid_maze_dfs_solver.
module gmd_chk (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       start,
  input logic       busy,
  input logic       mode_i,
  input logic       result_valid_o,
  input logic [2:0] event_kind_o,
  input logic       last_event_o
);

  // a result ends the command: the block is free in that cycle
  a_free_on_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> !busy) else $error("busy while result shown");

  // a load transaction never produces a result
  a_load_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && !mode_i) |=> !result_valid_o) else $error("result after load");

  a_exit_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && (event_kind_o == gmd_pkg::EV_EXIT ||
                        event_kind_o == gmd_pkg::EV_NOEXIT)) |-> last_event_o)
    else $error("final event not flagged");

  a_last_only_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && last_event_o) |->
      (event_kind_o == gmd_pkg::EV_EXIT || event_kind_o == gmd_pkg::EV_NOEXIT))
    else $error("last flag on non-final event");

endmodule

bind grid_maze_dfs_solver gmd_chk u_gmd_chk (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .mode_i         (mode_i),
  .result_valid_o (result_valid_o),
  .event_kind_o   (event_kind_o),
  .last_event_o   (last_event_o)
);

FILE: bench/gmd_checker.sv
// Checker for the grid maze DFS solver: watches the config, command and
// result channels, predicts each search event and compares. Uses gmd_pkg.
module gmd_checker (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic                       cfg_idx_i,
  input  logic [gmd_pkg::DimW-1:0]   cfg_data_i,
  input  logic                       start,
  input  logic                       busy,
  input  logic                       mode_i,
  input  logic [1:0]                 cell_code_i,
  input  logic                       result_valid_o,
  input  logic [2:0]                 event_kind_o,
  input  logic [1:0]                 direction_o,
  input  logic [gmd_pkg::CoordW-1:0] cell_row_o,
  input  logic [gmd_pkg::CoordW-1:0] cell_col_o,
  input  logic [gmd_pkg::CoordW-1:0] back_row_o,
  input  logic [gmd_pkg::CoordW-1:0] back_col_o,
  input  logic                       last_event_o,
  output int                         fail_count_o,
  output int                         pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [2:0] kind;
    logic [1:0] dir;
    logic [5:0] row;
    logic [5:0] col;
    logic [5:0] brow;
    logic [5:0] bcol;
    logic       last;
  } maze_event_t;

  maze_event_t event_q[$];

  logic [6:0]  width_reg, height_reg;
  logic        open_bits[gmd_pkg::Depth];
  logic        seen_bits[gmd_pkg::Depth];
  logic [14:0] frames[gmd_pkg::Depth];
  int          sp, load_pos, phase;
  logic        start_ok, exit_ok;
  int          start_r, start_c, exit_r, exit_c;

  function automatic int dim_of(logic [6:0] v);
    if (v == 0) return 1;
    if (v > 64) return 64;
    return int'(v);
  endfunction

  function automatic void new_maze();
    load_pos = 0;
    start_ok = 0;
    exit_ok  = 0;
    start_r = 0; start_c = 0; exit_r = 0; exit_c = 0;
    sp = 0;
    phase = gmd_pkg::PH_NOT_STARTED;
  endfunction

  function automatic void load_cell(logic [1:0] code);
    int w, h, r, c, idx;
    w = dim_of(width_reg);
    h = dim_of(height_reg);
    if (phase != gmd_pkg::PH_NOT_STARTED) new_maze();
    if (load_pos >= w * h) load_pos = 0;
    if (load_pos == 0) begin
      start_ok = 0;
      exit_ok  = 0;
    end
    r = load_pos / w;
    c = load_pos % w;
    idx = r * 64 + c;
    open_bits[idx] = (code == gmd_pkg::CODE_OPEN || code == gmd_pkg::CODE_START);
    seen_bits[idx] = 0;
    if (code == gmd_pkg::CODE_START) begin
      start_ok = 1; start_r = r; start_c = c;
    end
    if (code == gmd_pkg::CODE_OPEN && (r == 0 || r == h - 1 || c == 0 || c == w - 1)) begin
      exit_ok = 1; exit_r = r; exit_c = c;
    end
    load_pos++;
    if (load_pos >= w * h) load_pos = 0;
  endfunction

  function automatic maze_event_t mk(logic [2:0] k, int d, int r, int c,
                                     int br, int bc, logic l);
    maze_event_t e;
    e.kind = k; e.dir = d[1:0]; e.row = r[5:0]; e.col = c[5:0];
    e.brow = br[5:0]; e.bcol = bc[5:0]; e.last = l;
    return e;
  endfunction

  function automatic maze_event_t next_event();
    int w, h, sidx, cur_cell, d, r, c, nr, nc, nidx, prev;
    int drow[4], dcol[4];
    w = dim_of(width_reg);
    h = dim_of(height_reg);
    dcol = '{1, 0, -1, 0};
    drow = '{0, -1, 0, 1};
    if (phase == gmd_pkg::PH_DONE) return mk(gmd_pkg::EV_IDLE, 0, 0, 0, 0, 0, 0);
    if (phase == gmd_pkg::PH_EXITING) begin
      phase = gmd_pkg::PH_DONE;
      return mk(gmd_pkg::EV_EXIT, 0, exit_r, exit_c, 0, 0, 1);
    end
    if (phase == gmd_pkg::PH_NOT_STARTED) begin
      sidx = start_r * 64 + start_c;
      phase = gmd_pkg::PH_DONE;
      if (!start_ok) return mk(gmd_pkg::EV_NOEXIT, 0, 0, 0, 0, 0, 1);
      if (exit_ok && start_r == exit_r && start_c == exit_c)
        return mk(gmd_pkg::EV_EXIT, 0, start_r, start_c, 0, 0, 1);
      if (seen_bits[sidx]) return mk(gmd_pkg::EV_NOEXIT, 0, 0, 0, 0, 0, 1);
      seen_bits[sidx] = 1;
      frames[0] = {sidx[11:0], 3'd0};
      sp = 1;
      phase = gmd_pkg::PH_RUNNING;
      return mk(gmd_pkg::EV_START, 0, start_r, start_c, 0, 0, 0);
    end
    if (sp == 0) begin
      phase = gmd_pkg::PH_DONE;
      return mk(gmd_pkg::EV_NOEXIT, 0, 0, 0, 0, 0, 1);
    end
    cur_cell = frames[sp-1][14:3];
    d = frames[sp-1][2:0];
    r = cur_cell / 64;
    c = cur_cell % 64;
    for (int i = d; i < 4; i++) begin
      nr = r + drow[i];
      nc = c + dcol[i];
      if (nr < 0 || nc < 0 || nr >= h || nc >= w) continue;
      nidx = nr * 64 + nc;
      if (!open_bits[nidx] || seen_bits[nidx]) continue;
      frames[sp-1] = {cur_cell[11:0], 3'(i + 1)};
      if (exit_ok && nr == exit_r && nc == exit_c) phase = gmd_pkg::PH_EXITING;
      else begin
        seen_bits[nidx] = 1;
        if (sp < gmd_pkg::Depth) begin
          frames[sp] = {nidx[11:0], 3'd0};
          sp++;
        end
      end
      return mk(gmd_pkg::EV_MOVE, i, nr, nc, 0, 0, 0);
    end
    sp--;
    if (sp > 0) begin
      prev = frames[sp-1][14:3];
      return mk(gmd_pkg::EV_BACK, 0, r, c, prev / 64, prev % 64, 0);
    end
    phase = gmd_pkg::PH_DONE;
    return mk(gmd_pkg::EV_NOEXIT, 0, 0, 0, 0, 0, 1);
  endfunction

  task automatic cmp(string name, int exp_v, int act_v);
    if (exp_v != act_v) begin
      $display("%0t mismatch %s: expected %0d actual %0d", $realtime, name, exp_v, act_v);
      fail_count_o++;
    end
  endtask

  assign pending_o = event_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    maze_event_t e;
    if (!rst_ni) begin
      width_reg  = 7'd64;
      height_reg = 7'd64;
      new_maze();
      event_q.delete();
      fail_count_o = 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == gmd_pkg::REG_WIDTH) width_reg = cfg_data_i;
        else height_reg = cfg_data_i;
        new_maze();
      end
      if (start && !busy) begin
        if (!mode_i) load_cell(cell_code_i);
        else event_q.push_back(next_event());
      end
      if (result_valid_o) begin
        if (event_q.size() == 0) begin
          $display("%0t unexpected result transaction: expected none actual kind %0d",
                   $realtime, event_kind_o);
          fail_count_o++;
        end else begin
          e = event_q.pop_front();
          cmp("event_kind", e.kind, event_kind_o);
          cmp("direction", e.dir, direction_o);
          cmp("cell_row", e.row, cell_row_o);
          cmp("cell_col", e.col, cell_col_o);
          cmp("back_row", e.brow, back_row_o);
          cmp("back_col", e.bcol, back_col_o);
          cmp("last_event", e.last, last_event_o);
        end
      end
    end
  end

endmodule

FILE: bench/grid_maze_dfs_solver_tb.sv
// Top of the grid maze DFS solver bench: clock, reset, maze stimulus, verdict.
// Depends on gmd_pkg, grid_maze_dfs_solver and gmd_checker.
module grid_maze_dfs_solver_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic       MODE_LOAD = 1'b0;
  localparam logic       MODE_STEP = 1'b1;
  localparam logic [1:0] CODE_WALL = 2'd0;
  localparam logic [1:0] CODE_BAD  = 2'd3;   // illegal code, loads as a wall
  localparam int         SETTLE    = 20;     // load and result latency margin

  logic                        clk_i = 0;
  logic                        rst_ni = 0;
  logic                        cfg_we_i = 0;
  logic                        cfg_idx_i = 0;
  logic [gmd_pkg::DimW-1:0]    cfg_data_i = '0;
  logic                        start = 0;
  logic                        busy;
  logic                        mode_i = 0;
  logic [1:0]                  cell_code_i = '0;
  logic                        result_valid_o;
  logic [2:0]                  event_kind_o;
  logic [1:0]                  direction_o;
  logic [gmd_pkg::CoordW-1:0]  cell_row_o, cell_col_o, back_row_o, back_col_o;
  logic                        last_event_o;
  int                          fail_count, pending;

  int items;        // transactions sent so far
  int idle_pct;     // sender idle probability, percent
  int cur_w, cur_h; // effective maze size
  bit grid_loaded;  // every in-grid cell written under the current size

  always #2 clk_i = ~clk_i;

  grid_maze_dfs_solver u_dut (.*);

  gmd_checker u_chk (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i, .start, .busy,
    .mode_i, .cell_code_i, .result_valid_o, .event_kind_o, .direction_o,
    .cell_row_o, .cell_col_o, .back_row_o, .back_col_o, .last_event_o,
    .fail_count_o(fail_count), .pending_o(pending)
  );

  function automatic int eff_dim(int v);
    return (v == 0) ? 1 : (v > 64) ? 64 : v;
  endfunction

  // One command transaction; start stays high into the next one unless the
  // sender chooses to idle first.
  task automatic send_cmd(logic m, logic [1:0] code);
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    start       <= 1'b1;
    mode_i      <= m;
    cell_code_i <= code;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    items++;
  endtask

  // Config writes only with the block idle.
  task automatic write_size(int w, int h);
    start <= 1'b0;
    repeat (SETTLE) @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= gmd_pkg::REG_WIDTH;
    cfg_data_i <= 7'(w);
    @(posedge clk_i);
    cfg_idx_i  <= gmd_pkg::REG_HEIGHT;
    cfg_data_i <= 7'(h);
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    cur_w = eff_dim(w);
    cur_h = eff_dim(h);
    grid_loaded = 0;
  endtask

  // Load n cells; starts holds how many start cells to scatter (0..2).
  task automatic load_cells(int n, int open_pct, int starts);
    int s1, s2;
    logic [1:0] code;
    s1 = (starts > 0) ? $urandom_range(n - 1) : -1;
    s2 = (starts > 1) ? $urandom_range(n - 1) : -1;
    for (int p = 0; p < n; p++) begin
      if (p == s1 || p == s2) code = gmd_pkg::CODE_START;
      else if ($urandom_range(99) < open_pct) code = gmd_pkg::CODE_OPEN;
      else code = ($urandom_range(3) == 0) ? CODE_BAD : CODE_WALL;
      send_cmd(MODE_LOAD, code);
    end
  endtask

  // Step the search until its final event, then a few idle steps.
  task automatic run_search();
    bit done;
    int extra, guard;
    done = 0;
    extra = $urandom_range(1, 2);
    guard = 4 * cur_w * cur_h + 16;
    while (extra > 0 && guard > 0) begin
      send_cmd(MODE_STEP, 2'($urandom_range(3)));
      start <= 1'b0;
      while (!result_valid_o) @(posedge clk_i);
      if (done) extra--;
      if (last_event_o) done = 1;
      guard--;
    end
  endtask

  // A maze: full load, search, and sometimes a partial reload searched again.
  task automatic run_maze(int open_pct, int starts);
    load_cells(cur_w * cur_h, open_pct, starts);
    grid_loaded = 1;
    run_search();
    if (grid_loaded && $urandom_range(3) == 0) begin
      load_cells($urandom_range(1, cur_w * cur_h), open_pct, $urandom_range(2));
      run_search();
    end
  endtask

  initial begin
    items = 0;
    idle_pct = 12;
    cur_w = 64;
    cur_h = 64;
    grid_loaded = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: size extremes, clamping of 0 and 127, missing and doubled
    // starts, an all-open and an all-wall maze, a step with no maze loaded.
    send_cmd(MODE_STEP, CODE_WALL);
    start <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    write_size(1, 1);   run_maze(50, 1);
    write_size(0, 0);   run_maze(50, 0);
    write_size(2, 2);   run_maze(100, 1);
    write_size(3, 3);   run_maze(0, 2);
    write_size(127, 1); run_maze(70, 1);
    write_size(1, 64);  run_maze(70, 1);
    write_size(4, 3);
    send_cmd(MODE_STEP, gmd_pkg::CODE_OPEN);   // no start loaded: no exit
    start <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    run_maze(60, 2);

    // Random small mazes.
    while (items < 900) begin
      if (items > 300) idle_pct = 50;
      if (items > 600) idle_pct = 0;
      write_size($urandom_range(1, 7), $urandom_range(1, 7));
      run_maze($urandom_range(30, 90), ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 2));
    end

    start <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
    if (fail_count == 0)
      $display("grid_maze_dfs_solver regression: pass");
    else
      $display("grid_maze_dfs_solver regression: fail");
    $finish;
  end

  initial begin
    #20ms;
    $display("grid_maze_dfs_solver regression: fail");
    $finish;
  end

endmodule
